// ===== src/phf_pkg.sv =====
`default_nettype none

package phf_pkg;

   // Default geometry and identifier widths
   localparam int COORD_WIDTH = 20;
   localparam int ID_WIDTH    = 32;

   localparam int NUM_CORNERS = 8;
   localparam int NUM_FACES   = 6;
   localparam int NUM_AXES    = 3;

   localparam int CORNER_IDX_WIDTH = 3;
   localparam int FACE_IDX_WIDTH   = 3;
   localparam int CSR_INDEX_WIDTH  = 4;

   // Corner order of each face; the first three corners span the plane
   localparam logic [CORNER_IDX_WIDTH-1:0] FACE_TABLE [NUM_FACES][4] = '{
      '{3'd0, 3'd1, 3'd3, 3'd2},
      '{3'd4, 3'd5, 3'd7, 3'd6},
      '{3'd0, 3'd1, 3'd5, 3'd4},
      '{3'd1, 3'd3, 3'd7, 3'd5},
      '{3'd3, 3'd2, 3'd6, 3'd7},
      '{3'd2, 3'd0, 3'd4, 3'd6}
   };

endpackage

`default_nettype wire

// ===== src/phf_derive.sv =====
`default_nettype none

// Recomputes bounding box and outward face normals from the corners.
// A load step, a box pass over the eight corners, then edge, cross, normal, split and orient steps per face.
module phf_derive #(
   parameter int COORD_WIDTH = phf_pkg::COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [COORD_WIDTH-1:0]
                corner_coord [phf_pkg::NUM_CORNERS][phf_pkg::NUM_AXES],
   output logic busy,
   output logic signed [COORD_WIDTH-1:0] box_min [phf_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH-1:0] box_max [phf_pkg::NUM_AXES],
   output logic signed [2*COORD_WIDTH+2:0]
                normal [phf_pkg::NUM_FACES][phf_pkg::NUM_AXES]
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;          // edge vector component
   localparam int SW  = CW + 3;          // corner sum
   localparam int WW  = CW + 4;          // 8*centroid - 8*c0
   localparam int PW  = 2 * DW;          // cross product term
   localparam int NW  = 2 * CW + 3;      // normal component
   localparam int LB  = CW + 2;          // low limb bits
   localparam int HW  = NW - LB;         // high limb bits
   localparam int LW  = LB + 1;          // low limb as signed
   localparam int HPW = HW + WW;
   localparam int LPW = LW + WW;
   localparam int TW  = LB + HPW + 3;    // orientation dot product

   localparam int NC = phf_pkg::NUM_CORNERS;
   localparam int NF = phf_pkg::NUM_FACES;
   localparam int NA = phf_pkg::NUM_AXES;
   localparam int CIW = phf_pkg::CORNER_IDX_WIDTH;
   localparam int FIW = phf_pkg::FACE_IDX_WIDTH;

   localparam logic [CIW-1:0] LAST_CORNER = CIW'(NC - 1);
   localparam logic [FIW-1:0] LAST_FACE   = FIW'(NF - 1);

   localparam logic [2:0] STEP_EDGE   = 3'd0;
   localparam logic [2:0] STEP_CROSS  = 3'd1;
   localparam logic [2:0] STEP_NORMAL = 3'd2;
   localparam logic [2:0] STEP_SPLIT  = 3'd3;
   localparam logic [2:0] STEP_ORIENT = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BOX,
      ST_FACE
   } state_type;

   state_type            state_ff;
   logic [CIW-1:0]       cnt_ff;
   logic [FIW-1:0]       face_ff;
   logic [2:0]           step_ff;

   logic signed [CW-1:0] corner_sh_ff [NC][NA];
   logic signed [DW-1:0] fu_sh_ff [NF][NA];
   logic signed [DW-1:0] fv_sh_ff [NF][NA];
   logic signed [CW-1:0] fp_sh_ff [NF][NA];
   logic signed [DW-1:0] fu_in [NF][NA];
   logic signed [DW-1:0] fv_in [NF][NA];
   logic signed [CW-1:0] fp_in [NF][NA];

   logic signed [SW-1:0] sum_ff [NA];
   logic signed [CW-1:0] box_min_ff [NA];
   logic signed [CW-1:0] box_max_ff [NA];

   logic signed [DW-1:0]  u_ff [NA];
   logic signed [DW-1:0]  v_ff [NA];
   logic signed [WW-1:0]  w_ff [NA];
   logic signed [WW-1:0]  w_in [NA];
   logic signed [PW-1:0]  m_ff [6];
   logic signed [PW-1:0]  m_in [6];
   logic signed [NW-1:0]  n_ff [NA];
   logic signed [NW-1:0]  n_in [NA];
   logic signed [HPW-1:0] ph_ff [NA];
   logic signed [HPW-1:0] ph_in [NA];
   logic signed [LPW-1:0] pl_ff [NA];
   logic signed [LPW-1:0] pl_in [NA];
   logic signed [TW-1:0]  t_in;

   logic signed [NW-1:0]  normal_ff [NF][NA];

   // Per-face edges and base corner, fixed corner picks from the face table
   always_comb begin
      for (int f = 0; f < NF; f++) begin
         for (int a = 0; a < NA; a++) begin
            fp_in[f][a] = corner_coord[phf_pkg::FACE_TABLE[f][0]][a];
            fu_in[f][a] = DW'(corner_coord[phf_pkg::FACE_TABLE[f][1]][a])
                        - DW'(corner_coord[phf_pkg::FACE_TABLE[f][0]][a]);
            fv_in[f][a] = DW'(corner_coord[phf_pkg::FACE_TABLE[f][2]][a])
                        - DW'(corner_coord[phf_pkg::FACE_TABLE[f][1]][a]);
         end
      end
   end

   // Face datapath: offset to centroid, cross product, limb-split dot product
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         w_in[a] = WW'(sum_ff[a]) - (WW'(fp_sh_ff[0][a]) <<< 3);
      end
      m_in[0] = u_ff[1] * v_ff[2];
      m_in[1] = u_ff[2] * v_ff[1];
      m_in[2] = u_ff[2] * v_ff[0];
      m_in[3] = u_ff[0] * v_ff[2];
      m_in[4] = u_ff[0] * v_ff[1];
      m_in[5] = u_ff[1] * v_ff[0];
      n_in[0] = NW'(m_ff[0]) - NW'(m_ff[1]);
      n_in[1] = NW'(m_ff[2]) - NW'(m_ff[3]);
      n_in[2] = NW'(m_ff[4]) - NW'(m_ff[5]);
      for (int a = 0; a < NA; a++) begin
         ph_in[a] = $signed(n_ff[a][NW-1:LB]) * w_ff[a];
         pl_in[a] = $signed({1'b0, n_ff[a][LB-1:0]}) * w_ff[a];
      end
      t_in = ((TW'(ph_ff[0]) + TW'(ph_ff[1]) + TW'(ph_ff[2])) <<< LB)
           + TW'(pl_ff[0]) + TW'(pl_ff[1]) + TW'(pl_ff[2]);
   end

   // Sequencer with box and normal results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         face_ff  <= '0;
         step_ff  <= STEP_EDGE;
         for (int a = 0; a < NA; a++) begin
            sum_ff[a]     <= '0;
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
         for (int f = 0; f < NF; f++) begin
            for (int a = 0; a < NA; a++) begin
               normal_ff[f][a] <= '0;
            end
         end
      end else if (start) begin
         state_ff <= ST_BOX;
         cnt_ff   <= '0;
         face_ff  <= '0;
         step_ff  <= STEP_EDGE;
      end else begin
         unique case (state_ff)
            ST_BOX: begin
               for (int a = 0; a < NA; a++) begin
                  if (cnt_ff == '0) begin
                     sum_ff[a]     <= SW'(corner_sh_ff[0][a]);
                     box_min_ff[a] <= corner_sh_ff[0][a];
                     box_max_ff[a] <= corner_sh_ff[0][a];
                  end else begin
                     sum_ff[a] <= sum_ff[a] + SW'(corner_sh_ff[0][a]);
                     if (corner_sh_ff[0][a] < box_min_ff[a]) begin
                        box_min_ff[a] <= corner_sh_ff[0][a];
                     end
                     if (corner_sh_ff[0][a] > box_max_ff[a]) begin
                        box_max_ff[a] <= corner_sh_ff[0][a];
                     end
                  end
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CORNER) begin
                  state_ff <= ST_FACE;
                  face_ff  <= '0;
                  step_ff  <= STEP_EDGE;
               end
            end
            ST_FACE: begin
               unique case (step_ff)
                  STEP_EDGE:   step_ff <= STEP_CROSS;
                  STEP_CROSS:  step_ff <= STEP_NORMAL;
                  STEP_NORMAL: step_ff <= STEP_SPLIT;
                  STEP_SPLIT:  step_ff <= STEP_ORIENT;
                  STEP_ORIENT: begin
                     // flip when the normal points toward the centroid
                     for (int a = 0; a < NA; a++) begin
                        normal_ff[face_ff][a] <= (t_in > 0) ? -n_ff[a] : n_ff[a];
                     end
                     step_ff <= STEP_EDGE;
                     if (face_ff == LAST_FACE) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        face_ff <= face_ff + 1'b1;
                     end
                  end
                  default: step_ff <= STEP_EDGE;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Shift lines and face datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         corner_sh_ff <= corner_coord;
         fu_sh_ff     <= fu_in;
         fv_sh_ff     <= fv_in;
         fp_sh_ff     <= fp_in;
      end else begin
         if (state_ff == ST_BOX) begin
            for (int i = 0; i < NC - 1; i++) begin
               corner_sh_ff[i] <= corner_sh_ff[i+1];
            end
         end
         if (state_ff == ST_FACE && step_ff == STEP_ORIENT) begin
            for (int f = 0; f < NF - 1; f++) begin
               fu_sh_ff[f] <= fu_sh_ff[f+1];
               fv_sh_ff[f] <= fv_sh_ff[f+1];
               fp_sh_ff[f] <= fp_sh_ff[f+1];
            end
         end
      end
      if (step_ff == STEP_EDGE) begin
         u_ff <= fu_sh_ff[0];
         v_ff <= fv_sh_ff[0];
         w_ff <= w_in;
      end
      if (step_ff == STEP_CROSS) begin
         m_ff <= m_in;
      end
      if (step_ff == STEP_NORMAL) begin
         n_ff <= n_in;
      end
      if (step_ff == STEP_SPLIT) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign box_min = box_min_ff;
   assign box_max = box_max_ff;
   assign normal  = normal_ff;

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_BOX) && (cnt_ff == '0))
      else $error("derive did not restart on start");

   a_face_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FACE) |-> (step_ff <= STEP_ORIENT) && (face_ff <= LAST_FACE))
      else $error("face sequencer out of range");

   a_box_to_face: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BOX) && (cnt_ff == LAST_CORNER) && !start
      |=> (state_ff == ST_FACE) && (face_ff == '0) && (step_ff == STEP_EDGE))
      else $error("box pass did not hand over to first face");

endmodule

`default_nettype wire

// ===== src/point_in_hexahedron_filter.sv =====
`default_nettype none

// Point-in-hexahedron filter. Eight corner registers (csr index 0..7, x/y/z
// packed low to high, two's complement) define a hexahedron; each point
// transaction is tested against the corners' bounding box (inclusive) and the
// six face half-spaces, and its id comes out on the rsp channel only when the
// point lies inside. The point pipeline takes one transaction per cycle while
// req_stall is low and passes it through the p1, d2, ph3/pl3, hs4/ls4 and
// result registers before rsp_valid rises; rejected points leave no result.
// After every corner write a face-serial derivation sequencer rebuilds the box
// and normals, and req_stall goes high after the write and stays high until it is done.
module point_in_hexahedron_filter #(
   parameter int COORD_WIDTH = phf_pkg::COORD_WIDTH,
   parameter int ID_WIDTH    = phf_pkg::ID_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_point_x,
   input  logic signed [COORD_WIDTH-1:0]        req_point_y,
   input  logic signed [COORD_WIDTH-1:0]        req_point_z,
   input  logic [ID_WIDTH-1:0]                  req_point_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ID_WIDTH-1:0]                  rsp_inside_id,
   input  logic                                 csr_write,
   input  logic [phf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [3*COORD_WIDTH-1:0]             csr_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;           // point minus base corner
   localparam int NW  = 2 * CW + 3;       // normal component
   localparam int LB  = CW + 2;           // low limb bits
   localparam int HW  = NW - LB;
   localparam int LW  = LB + 1;
   localparam int HPW = HW + DW;
   localparam int LPW = LW + DW;
   localparam int HSW = HPW + 2;
   localparam int LSW = LPW + 2;
   localparam int TW  = LB + HSW + 1;

   localparam int NC  = phf_pkg::NUM_CORNERS;
   localparam int NF  = phf_pkg::NUM_FACES;
   localparam int NA  = phf_pkg::NUM_AXES;
   localparam int IW  = phf_pkg::CSR_INDEX_WIDTH;
   localparam int CIW = phf_pkg::CORNER_IDX_WIDTH;
   localparam logic [IW-1:0] CORNER_LIMIT = IW'(NC);

   logic [3*CW-1:0]      corner_ff [NC];
   logic signed [CW-1:0] corner_coord [NC][NA];
   logic                 start_ff;
   logic                 derive_busy;
   logic signed [CW-1:0] box_min [NA];
   logic signed [CW-1:0] box_max [NA];
   logic signed [NW-1:0] normal [NF][NA];

   logic ready1, ready2, ready3, ready4, ready5;
   logic accept;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [CW-1:0] p1_ff [NA];
   logic [ID_WIDTH-1:0]  id1_ff, id2_ff, id3_ff, id4_ff;
   logic signed [DW-1:0] d2_ff [NF][NA];
   logic signed [DW-1:0] d_in [NF][NA];
   logic                 box2_ff, box3_ff, box4_ff;
   logic                 box_in;
   logic signed [HPW-1:0] ph3_ff [NF][NA];
   logic signed [LPW-1:0] pl3_ff [NF][NA];
   logic signed [HPW-1:0] ph_in [NF][NA];
   logic signed [LPW-1:0] pl_in [NF][NA];
   logic signed [HSW-1:0] hs4_ff [NF];
   logic signed [LSW-1:0] ls4_ff [NF];
   logic signed [HSW-1:0] hs_in [NF];
   logic signed [LSW-1:0] ls_in [NF];
   logic signed [TW-1:0]  t_in [NF];
   logic                  inside_in;
   logic                  rsp_valid_ff;
   logic [ID_WIDTH-1:0]   rsp_inside_id_ff;

   // Corner registers; a write restarts the derivation
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            corner_ff[i] <= '0;
         end
      end else begin
         start_ff <= 1'b0;
         if (csr_write && (csr_index < CORNER_LIMIT)) begin
            corner_ff[csr_index[CIW-1:0]] <= csr_data;
            start_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         for (int a = 0; a < NA; a++) begin
            corner_coord[i][a] = $signed(corner_ff[i][a*CW +: CW]);
         end
      end
   end

   phf_derive #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_derive (
      .clock        (clock),
      .reset        (reset),
      .start        (start_ff),
      .corner_coord (corner_coord),
      .busy         (derive_busy),
      .box_min      (box_min),
      .box_max      (box_max),
      .normal       (normal)
   );

   // Backpressure chain: a stage moves when it is empty or the next one moves
   assign ready5    = !rsp_valid_ff || !rsp_stall;
   assign ready4    = !v4_ff || ready5;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1 || derive_busy || start_ff;
   assign accept    = req_valid && !req_stall;

   // Stage datapath: offsets and box test, limb products, sums, sign
   always_comb begin
      box_in = 1'b1;
      for (int a = 0; a < NA; a++) begin
         if (p1_ff[a] < box_min[a] || p1_ff[a] > box_max[a]) begin
            box_in = 1'b0;
         end
      end
      for (int f = 0; f < NF; f++) begin
         for (int a = 0; a < NA; a++) begin
            d_in[f][a] = DW'(p1_ff[a])
                       - DW'(corner_coord[phf_pkg::FACE_TABLE[f][0]][a]);
            ph_in[f][a] = $signed(normal[f][a][NW-1:LB]) * d2_ff[f][a];
            pl_in[f][a] = $signed({1'b0, normal[f][a][LB-1:0]}) * d2_ff[f][a];
         end
         hs_in[f] = HSW'(ph3_ff[f][0]) + HSW'(ph3_ff[f][1]) + HSW'(ph3_ff[f][2]);
         ls_in[f] = LSW'(pl3_ff[f][0]) + LSW'(pl3_ff[f][1]) + LSW'(pl3_ff[f][2]);
         t_in[f]  = (TW'(hs4_ff[f]) <<< LB) + TW'(ls4_ff[f]);
      end
      inside_in = box4_ff;
      for (int f = 0; f < NF; f++) begin
         if (t_in[f] > 0) begin
            inside_in = 1'b0;
         end
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= accept;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
         if (ready5) rsp_valid_ff <= v4_ff && inside_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (ready1 && accept) begin
         p1_ff[0] <= req_point_x;
         p1_ff[1] <= req_point_y;
         p1_ff[2] <= req_point_z;
         id1_ff   <= req_point_id;
      end
      if (ready2) begin
         d2_ff   <= d_in;
         box2_ff <= box_in;
         id2_ff  <= id1_ff;
      end
      if (ready3) begin
         ph3_ff  <= ph_in;
         pl3_ff  <= pl_in;
         box3_ff <= box2_ff;
         id3_ff  <= id2_ff;
      end
      if (ready4) begin
         hs4_ff  <= hs_in;
         ls4_ff  <= ls_in;
         box4_ff <= box3_ff;
         id4_ff  <= id3_ff;
      end
      if (ready5) begin
         rsp_inside_id_ff <= id4_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inside_id = rsp_inside_id_ff;

   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index < CORNER_LIMIT) |=> req_stall)
      else $error("input open right after a corner write");

   a_last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !ready5 |=> v4_ff && (id4_ff == $past(id4_ff)))
      else $error("last pipeline stage lost a stalled transaction");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v4_ff && box4_ff))
      else $error("result without a box-passing transaction behind it");

endmodule

`default_nettype wire
